### hw/rtl/skt_pkg.sv
// Shared types and constants for the sorted key table search block.
package skt_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UPDATE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SIDE0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SIDE1 = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]       mode;
    logic             side;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic [VAL_W-1:0] stored_value;
    logic             changed;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             side;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] new_value;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

### hw/rtl/sorted_key_table_search.sv
// Top level of the sorted key table search block.
// Two tables of 4096 entries (64-bit key, 16-bit value), one per side, held
// in on-chip memory with undefined contents after reset; load each table in
// ascending key order and set its count register before searching. Items are
// pushed into a two-entry command queue and carried out one at a time by the
// search engine; results leave through a two-entry result queue. A load or
// read by index reads the addressed entry once; a lookup or update makes
// one probe per cycle, up to 13 probes for a full table, through the single
// read port of the key memory. Each command is registered in the command
// queue before the engine takes it.
module sorted_key_table_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  skt_pkg::req_t                 item,
  output logic                          empty,
  input  logic                          pop,
  output skt_pkg::rsp_t                 result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skt_pkg::CNT_W-1:0]     cfg_data
);
  import skt_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  skt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  skt_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_valid),
    .wr_data  (cmd),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_cmd)
  );

  skt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

### hw/rtl/skt_front.sv
// Front end: count registers, item intake and command build.
module skt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  skt_pkg::req_t                 item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skt_pkg::CNT_W-1:0]     cfg_data,
  output logic                          cmd_valid,
  output skt_pkg::cmd_t                 cmd
);
  import skt_pkg::*;

  logic [CNT_W-1:0] count_side0;
  logic [CNT_W-1:0] count_side1;
  logic [CNT_W-1:0] count_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_side0 <= '0;
      count_side1 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COUNT_SIDE0: count_side0 <= cfg_data;
        REG_COUNT_SIDE1: count_side1 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count_sel = item.side ? count_side1 : count_side0;

  always_comb begin
    cmd.mode      = item.mode;
    cmd.side      = item.side;
    cmd.key       = item.key;
    cmd.idx       = item.entry_index;
    cmd.new_value = item.new_value;
    // clamp to table depth
    cmd.count     = (count_sel > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_sel;
  end

  assign cmd_valid = push;

endmodule

### hw/rtl/skt_cmd_queue.sv
// Short command queue between front end and search engine.
module skt_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  skt_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output skt_pkg::cmd_t rd_data
);
  import skt_pkg::*;

  cmd_t              slots [Q_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_wr;
  logic              do_rd;

  assign full     = (cnt == QCNT_W'(Q_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = slots[rptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) wptr <= wptr + QPTR_W'(1);
      if (do_rd) rptr <= rptr + QPTR_W'(1);
      if (do_wr && !do_rd) cnt <= cnt + QCNT_W'(1);
      else if (do_rd && !do_wr) cnt <= cnt - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_data;
  end

endmodule

### hw/rtl/skt_engine.sv
// Back end: table memories, binary search sequencer and result queue.
module skt_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  skt_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          empty,
  input  logic          pop,
  output skt_pkg::rsp_t result
);
  import skt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_IDXRD = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [1:0]       mode;
  logic             side;
  logic [KEY_W-1:0] key;
  logic [IDX_W-1:0] idx;
  logic [VAL_W-1:0] new_value;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] lo_next;
  logic [CNT_W-1:0] hix;
  logic [CNT_W-1:0] hix_next;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] mid_next;
  rsp_t             res;
  rsp_t             res_next;

  logic [KEY_W-1:0] key_mem [2*TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [2*TABLE_DEPTH];
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic             wr_key_en;
  logic             wr_val_en;
  logic [ADDR_W-1:0] wr_addr;

  rsp_t              rq [Q_DEPTH];
  logic [QPTR_W-1:0] rq_wptr;
  logic [QPTR_W-1:0] rq_rptr;
  logic [QCNT_W-1:0] rq_cnt;
  logic              rq_full;
  logic              res_push;
  logic              res_pop;
  logic              upd_hit;

  // floor((lo + hi) / 2) with hi = hix - 1, lo < hix
  function automatic logic [IDX_W-1:0] midpoint(input logic [CNT_W-1:0] l,
                                                input logic [CNT_W-1:0] h);
    logic [CNT_W:0] s;
    s = {1'b0, l} + {1'b0, h} - (CNT_W+1)'(1);
    return s[IDX_W:1];
  endfunction

  assign upd_hit = (mode == MODE_UPDATE) && (val_rd != new_value);

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hix_next   = hix;
    mid_next   = mid;
    res_next   = res;
    cmd_pop    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = {side, mid};
    wr_key_en  = 1'b0;
    wr_val_en  = 1'b0;
    wr_addr    = {side, idx};
    res_push   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          res_next = '0;
          if (cmd.mode == MODE_LOAD || cmd.mode == MODE_READ) begin
            rd_en      = 1'b1;
            rd_addr    = {cmd.side, cmd.idx};
            state_next = S_IDXRD;
          end else begin
            lo_next  = '0;
            hix_next = cmd.count;
            mid_next = midpoint('0, cmd.count);
            if (cmd.count == '0) begin
              state_next = S_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = {cmd.side, mid_next};
              state_next = S_PROBE;
            end
          end
        end
      end
      S_IDXRD: begin
        res_next.found        = 1'b1;
        res_next.match_index  = idx;
        res_next.stored_value = val_rd;
        res_next.changed      = 1'b0;
        wr_key_en  = (mode == MODE_LOAD);
        wr_val_en  = (mode == MODE_LOAD);
        state_next = S_DONE;
      end
      S_PROBE: begin
        if (key == key_rd) begin
          res_next.found        = 1'b1;
          res_next.match_index  = mid;
          res_next.stored_value = val_rd;
          res_next.changed      = upd_hit;
          wr_val_en  = upd_hit;
          wr_addr    = {side, mid};
          state_next = S_DONE;
        end else begin
          if (key < key_rd) hix_next = {1'b0, mid};
          else lo_next = {1'b0, mid} + CNT_W'(1);
          mid_next = midpoint(lo_next, hix_next);
          if (lo_next >= hix_next) begin
            state_next = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = {side, mid_next};
          end
        end
      end
      S_DONE: begin
        if (!rq_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hix <= hix_next;
    mid <= mid_next;
    res <= res_next;
    if (cmd_pop) begin
      mode      <= cmd.mode;
      side      <= cmd.side;
      key       <= cmd.key;
      idx       <= cmd.idx;
      new_value <= cmd.new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_rd <= key_mem[rd_addr];
      val_rd <= val_mem[rd_addr];
    end
    if (wr_key_en) key_mem[wr_addr] <= key;
    if (wr_val_en) val_mem[wr_addr] <= new_value;
  end

  // result queue
  assign rq_full = (rq_cnt == QCNT_W'(Q_DEPTH));
  assign empty   = (rq_cnt == '0);
  assign result  = rq[rq_rptr];
  assign res_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wptr <= '0;
      rq_rptr <= '0;
      rq_cnt  <= '0;
    end else begin
      if (res_push) rq_wptr <= rq_wptr + QPTR_W'(1);
      if (res_pop) rq_rptr <= rq_rptr + QPTR_W'(1);
      if (res_push && !res_pop) rq_cnt <= rq_cnt + QCNT_W'(1);
      else if (res_pop && !res_push) rq_cnt <= rq_cnt - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) rq[rq_wptr] <= res;
  end

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> lo < hix)
    else $error("probe with empty search window");

  a_changed_found: assert property (@(posedge clk) disable iff (rst)
    res_push && res.changed |-> res.found && mode == MODE_UPDATE)
    else $error("changed flag without update hit");

  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_cnt <= QCNT_W'(Q_DEPTH))
    else $error("result queue overrun");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state != S_IDLE)
    else $error("command taken but sequencer stayed idle");

endmodule
